/* design/bitk_pkg.sv */
package bitk_pkg;

    // Store geometry.
    localparam int VERTICES = 1024;
    localparam int SLOTS    = 4;
    localparam int VTX_W    = $clog2(VERTICES);
    localparam int SLOT_W   = (SLOTS > 2) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int KIND_W   = 1;
    localparam int VIDX_W   = 10;
    localparam int BONE_W   = 8;
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W   = 16;
    localparam int STATUS_W = 3;
    localparam int VLIM_W   = 11;
    localparam int BLIM_W   = 9;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = WEIGHT_W + $clog2(SLOTS);

    // Divider sequencing: one quotient bit per cycle.
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [WEIGHT_W-1:0] ONE_FIX = WEIGHT_W'(65536);

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ADD      = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FINALIZE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FREE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_BONE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READOUT    = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_LIMIT = 1'b0;
    localparam logic CFG_BONE_LIMIT   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VIDX_W-1:0]   vertex_index;
        logic [BONE_W-1:0]   bone_index;
        logic [WEIGHT_W-1:0] weight;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BONE_W-1:0]   slot_bone;
        logic [WEIGHT_W-1:0] slot_weight;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
    } slot_t;

    typedef slot_t [SLOTS-1:0] row_t;

    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] addr;
        row_t             wdata;
    } store_req_t;

    typedef struct packed {
        logic clearing;
        row_t rdata;
    } store_stat_t;

    typedef struct packed {
        logic                start;
        logic [WEIGHT_W-1:0] dividend;
        logic [SUM_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                active;
        logic                done;
        logic [WEIGHT_W-1:0] quotient;
    } div_stat_t;

endpackage

/* design/bone_influence_top_k.sv */
// Bone influence store with top-k limiting and weight normalization.
// Requests arrive on start/request and are taken at a clock edge where start
// is high and busy is low. An add request stores a (bone, weight) influence
// into its vertex's slot row and returns one status result. A finalize
// request normalizes, sorts by descending weight, normalizes again, writes
// the row back and returns one readout result per slot, the last one flagged.
// Results appear on result for exactly one cycle, marked by result_valid; the
// receiver cannot stall, so no result is ever held back.
// A rejected request (bad vertex or bad bone) reports in the cycle after
// acceptance and busy stays low. An add passes through the read, load and
// add states and reports as it returns to idle. A finalize reads the row,
// sums it, computes four quotients of 17 steps each on the shared bit-serial
// divider, runs four sort rounds, sums and divides again, writes the row back
// and then returns its results on consecutive cycles; an empty vertex skips
// the divisions. busy stays high until the last result of a request appears.
// After reset, busy stays high while the slot memory is cleared row by row.
// vertex_limit and bone_limit return to 1024 and 256 and may be rewritten
// through cfg_write whenever no request is open.
module bone_influence_top_k (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bitk_pkg::request_t              request,
    output logic                            result_valid,
    output bitk_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [bitk_pkg::CFG_W-1:0]      cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_SORT   = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    localparam logic [bitk_pkg::SLOT_W-1:0] LAST_SLOT =
        bitk_pkg::SLOT_W'(bitk_pkg::SLOTS - 1);

    logic [3:0]                       state_reg;
    logic [3:0]                       state_next;
    logic [bitk_pkg::VLIM_W-1:0]      vertex_limit_reg;
    logic [bitk_pkg::BLIM_W-1:0]      bone_limit_reg;
    logic [bitk_pkg::KIND_W-1:0]      kind_reg;
    logic [bitk_pkg::KIND_W-1:0]      kind_next;
    logic [bitk_pkg::VIDX_W-1:0]      vertex_reg;
    logic [bitk_pkg::VIDX_W-1:0]      vertex_next;
    logic [bitk_pkg::BONE_W-1:0]      bone_reg;
    logic [bitk_pkg::BONE_W-1:0]      bone_next;
    logic [bitk_pkg::WEIGHT_W-1:0]    weight_reg;
    logic [bitk_pkg::WEIGHT_W-1:0]    weight_next;
    logic [bitk_pkg::WEIGHT_W-1:0]    w_reg [bitk_pkg::SLOTS];
    logic [bitk_pkg::WEIGHT_W-1:0]    w_next [bitk_pkg::SLOTS];
    logic [bitk_pkg::BONE_W-1:0]      b_reg [bitk_pkg::SLOTS];
    logic [bitk_pkg::BONE_W-1:0]      b_next [bitk_pkg::SLOTS];
    logic [bitk_pkg::SUM_W-1:0]       sum_reg;
    logic [bitk_pkg::SUM_W-1:0]       sum_next;
    logic [bitk_pkg::SUM_W-1:0]       sum_all;
    logic [bitk_pkg::SLOT_W-1:0]      slot_reg;
    logic [bitk_pkg::SLOT_W-1:0]      slot_next;
    logic [bitk_pkg::SLOT_W-1:0]      round_reg;
    logic [bitk_pkg::SLOT_W-1:0]      round_next;
    logic                             phase_reg;
    logic                             phase_next;
    logic                             result_valid_reg;
    logic                             result_valid_next;
    bitk_pkg::result_t                result_reg;
    bitk_pkg::result_t                result_next;

    logic                             accept;
    logic                             vertex_bad;
    logic                             bone_bad;
    logic                             free_found;
    logic [bitk_pkg::SLOT_W-1:0]      free_idx;
    logic [bitk_pkg::SLOT_W-1:0]      min_idx;
    logic [bitk_pkg::WEIGHT_W-1:0]    min_w;
    bitk_pkg::row_t                   row_cur;
    bitk_pkg::row_t                   row_add;

    bitk_pkg::store_req_t             store_req;
    bitk_pkg::store_stat_t            store_stat;
    bitk_pkg::div_req_t               div_req;
    bitk_pkg::div_stat_t              div_stat;

    bitk_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .stat  (store_stat)
    );

    bitk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Handshake and request checks.
    assign busy   = (state_reg != S_IDLE) || store_stat.clearing;
    assign accept = start && !busy;

    assign vertex_bad =
        (32'(request.vertex_index) >= 32'(vertex_limit_reg)) ||
        (32'(request.vertex_index) >= bitk_pkg::VERTICES);
    assign bone_bad = (request.kind == bitk_pkg::KIND_ADD) &&
                      ({1'b0, request.bone_index} >= bone_limit_reg);

    // Current row as held in the working registers.
    always_comb
    begin
        for (int i = 0; i < bitk_pkg::SLOTS; i++)
        begin
            row_cur[i].bone   = b_reg[i];
            row_cur[i].weight = w_reg[i];
        end
    end

    // Weight sum for normalization.
    always_comb
    begin
        sum_all = '0;
        for (int i = 0; i < bitk_pkg::SLOTS; i++)
        begin
            sum_all = sum_all + bitk_pkg::SUM_W'(w_reg[i]);
        end
    end

    // Add decision: first free slot, otherwise the smallest (lowest on ties).
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        min_idx    = '0;
        min_w      = w_reg[0];
        for (int i = 0; i < bitk_pkg::SLOTS; i++)
        begin
            if (!free_found && (w_reg[i] == '0))
            begin
                free_found = 1'b1;
                free_idx   = bitk_pkg::SLOT_W'(i);
            end
        end
        for (int i = 1; i < bitk_pkg::SLOTS; i++)
        begin
            if (w_reg[i] < min_w)
            begin
                min_w   = w_reg[i];
                min_idx = bitk_pkg::SLOT_W'(i);
            end
        end
        row_add = row_cur;
        if (free_found)
        begin
            row_add[free_idx].bone   = bone_reg;
            row_add[free_idx].weight = weight_reg;
        end
        else
        begin
            row_add[min_idx].bone   = bone_reg;
            row_add[min_idx].weight = weight_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        vertex_next       = vertex_reg;
        bone_next         = bone_reg;
        weight_next       = weight_reg;
        w_next            = w_reg;
        b_next            = b_reg;
        sum_next          = sum_reg;
        slot_next         = slot_reg;
        round_next        = round_reg;
        phase_next        = phase_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        result_next.last  = 1'b1;

        store_req.we      = 1'b0;
        store_req.addr    = bitk_pkg::VTX_W'(vertex_reg);
        store_req.wdata   = row_add;

        div_req.start     = 1'b0;
        div_req.dividend  = w_reg[slot_reg];
        div_req.divisor   = sum_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (vertex_bad)
                    begin
                        result_valid_next  = 1'b1;
                        result_next.status = bitk_pkg::ST_BAD_VERTEX;
                    end
                    else if (bone_bad)
                    begin
                        result_valid_next  = 1'b1;
                        result_next.status = bitk_pkg::ST_BAD_BONE;
                    end
                    else
                    begin
                        kind_next   = request.kind;
                        vertex_next = request.vertex_index;
                        bone_next   = request.bone_index;
                        weight_next = (request.weight > bitk_pkg::ONE_FIX) ?
                                      bitk_pkg::ONE_FIX : request.weight;
                        state_next  = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                for (int i = 0; i < bitk_pkg::SLOTS; i++)
                begin
                    w_next[i] = store_stat.rdata[i].weight;
                    b_next[i] = store_stat.rdata[i].bone;
                end
                phase_next = 1'b0;
                state_next = (kind_reg == bitk_pkg::KIND_ADD) ? S_ADD : S_SUM;
            end

            S_ADD:
            begin
                result_valid_next = 1'b1;
                if (free_found)
                begin
                    store_req.we       = 1'b1;
                    result_next.status = bitk_pkg::ST_FREE;
                end
                else if (weight_reg > min_w)
                begin
                    store_req.we       = 1'b1;
                    result_next.status = bitk_pkg::ST_REPLACED;
                end
                else
                begin
                    result_next.status = bitk_pkg::ST_DROPPED;
                end
                state_next = S_IDLE;
            end

            S_SUM:
            begin
                sum_next  = sum_all;
                slot_next = '0;
                if (sum_all == '0)
                begin
                    // An empty vertex keeps its weights as they are.
                    round_next = '0;
                    state_next = phase_reg ? S_WRITE : S_SORT;
                end
                else
                begin
                    state_next = S_DSTART;
                end
            end

            S_DSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    w_next[slot_reg] = div_stat.quotient;
                    if (slot_reg == LAST_SLOT)
                    begin
                        round_next = '0;
                        state_next = phase_reg ? S_WRITE : S_SORT;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end

            S_SORT:
            begin
                // Odd-even transposition round; swapping only on strictly
                // smaller keeps equal weights in slot order.
                for (int i = 0; i < bitk_pkg::SLOTS - 1; i++)
                begin
                    if ((i % 2) == int'(round_reg[0]))
                    begin
                        if (w_reg[i] < w_reg[i+1])
                        begin
                            w_next[i]   = w_reg[i+1];
                            w_next[i+1] = w_reg[i];
                            b_next[i]   = b_reg[i+1];
                            b_next[i+1] = b_reg[i];
                        end
                    end
                end
                if (round_reg == LAST_SLOT)
                begin
                    phase_next = 1'b1;
                    state_next = S_SUM;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end

            S_WRITE:
            begin
                store_req.we    = 1'b1;
                store_req.wdata = row_cur;
                slot_next       = '0;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                result_valid_next       = 1'b1;
                result_next.status      = bitk_pkg::ST_READOUT;
                result_next.slot_bone   = b_reg[slot_reg];
                result_next.slot_weight = w_reg[slot_reg];
                result_next.last        = (slot_reg == LAST_SLOT);
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_reg         <= '0;
            round_reg        <= '0;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            vertex_limit_reg <= bitk_pkg::VLIM_W'(1024);
            bone_limit_reg   <= bitk_pkg::BLIM_W'(256);
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            round_reg        <= round_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bitk_pkg::CFG_VERTEX_LIMIT:
                    begin
                        vertex_limit_reg <= cfg_data;
                    end
                    bitk_pkg::CFG_BONE_LIMIT:
                    begin
                        bone_limit_reg <= cfg_data[bitk_pkg::BLIM_W-1:0];
                    end
                    default:
                    begin
                        vertex_limit_reg <= vertex_limit_reg;
                    end
                endcase
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        vertex_reg <= vertex_next;
        bone_reg   <= bone_next;
        weight_reg <= weight_next;
        w_reg      <= w_next;
        b_reg      <= b_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The divider only runs while a finalize request is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.active |-> (state_reg == S_DWAIT))
        else $error("divider running outside the divide wait state");

    // Readout weights never exceed one after normalization.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == bitk_pkg::ST_READOUT)
        |-> (result.slot_weight <= bitk_pkg::ONE_FIX))
        else $error("readout weight above one");

    // Every status result is the only result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != bitk_pkg::ST_READOUT)
        |-> (result.last && (result.slot_bone == '0) && (result.slot_weight == '0)))
        else $error("status result without last flag or with payload");

    // Memory writes come only from the add and write-back steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.we |-> ((state_reg == S_ADD) || (state_reg == S_WRITE)))
        else $error("unexpected slot store write");

    // No request is taken during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_stat.clearing |-> busy)
        else $error("block not busy while clearing the store");

endmodule

/* design/bitk_div.sv */
// Restoring divider computing floor(dividend * 2^16 / divisor), one bit per cycle.
// The caller guarantees dividend <= divisor and divisor != 0, so the quotient
// fits in WEIGHT_W bits and the upper dividend bits never produce a quotient bit.
module bitk_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bitk_pkg::div_req_t req,
    output bitk_pkg::div_stat_t stat
);

    logic [bitk_pkg::SUM_W-1:0]    rem_reg;
    logic [bitk_pkg::SUM_W-1:0]    rem_next;
    logic [bitk_pkg::SUM_W-1:0]    dvsr_reg;
    logic [bitk_pkg::FRAC_W:0]     shift_reg;
    logic [bitk_pkg::FRAC_W:0]     shift_next;
    logic [bitk_pkg::WEIGHT_W-1:0] quo_reg;
    logic [bitk_pkg::WEIGHT_W-1:0] quo_next;
    logic [bitk_pkg::DCNT_W-1:0]   cnt_reg;
    logic [bitk_pkg::DCNT_W-1:0]   cnt_next;
    logic                          done_reg;
    logic                          done_next;
    logic [bitk_pkg::SUM_W:0]      trial;
    logic                          fits;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, shift_reg[bitk_pkg::FRAC_W]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            // The top dividend bits seed the remainder; the rest shift in.
            rem_next   = bitk_pkg::SUM_W'(req.dividend[bitk_pkg::WEIGHT_W-1:1]);
            shift_next = {req.dividend[0], {bitk_pkg::FRAC_W{1'b0}}};
            quo_next   = '0;
            cnt_next   = bitk_pkg::DCNT_W'(bitk_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next   = fits ? bitk_pkg::SUM_W'(trial - {1'b0, dvsr_reg})
                              : bitk_pkg::SUM_W'(trial);
            shift_next = {shift_reg[bitk_pkg::FRAC_W-1:0], 1'b0};
            quo_next   = {quo_reg[bitk_pkg::WEIGHT_W-2:0], fits};
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == bitk_pkg::DCNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        quo_reg   <= quo_next;
        if (req.start)
        begin
            dvsr_reg <= req.divisor;
        end
    end

    assign stat.active   = (cnt_reg != '0);
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

/* design/bitk_store.sv */
// Slot store: one row of all slots per vertex, registered read.
// After reset a clearing pass zeroes one row per cycle.
module bitk_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bitk_pkg::store_req_t req,
    output bitk_pkg::store_stat_t stat
);

    bitk_pkg::row_t             mem [0:bitk_pkg::VERTICES-1];
    bitk_pkg::row_t             rdata_reg;
    logic                       clearing_reg;
    logic [bitk_pkg::VTX_W-1:0] clr_addr_reg;

    // Clearing pass sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == bitk_pkg::VTX_W'(bitk_pkg::VERTICES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Memory array with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign stat.clearing = clearing_reg;
    assign stat.rdata    = rdata_reg;

endmodule

/* tb/sv/testbench.sv */
module testbench;

    import bitk_pkg::*;

    typedef logic [SLOTS-1:0][WEIGHT_W-1:0] weight_row_t;
    typedef logic [SLOTS-1:0][BONE_W-1:0]   bone_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    request_t           request = '0;
    logic               result_valid;
    result_t            result;
    logic               cfg_write = 1'b0;
    logic               cfg_index = CFG_VERTEX_LIMIT;
    logic [CFG_W-1:0]   cfg_data = '0;

    // Shadow copy of the slot store and the limit registers.
    logic [BONE_W-1:0]   shadow_bone [VERTICES*SLOTS];
    logic [WEIGHT_W-1:0] shadow_weight [VERTICES*SLOTS];
    logic [VLIM_W-1:0]   shadow_vertex_limit = VLIM_W'(1024);
    logic [BLIM_W-1:0]   shadow_bone_limit = BLIM_W'(256);

    // Results predicted for accepted requests, oldest first.
    result_t awaited_results [$];
    int      error_count = 0;
    bit      no_idle = 1'b0;

    bone_influence_top_k dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Divide every weight by the row sum, truncating; an all-zero row is left alone.
    function automatic weight_row_t normalize_weights(input weight_row_t w);
        logic [63:0] sum;
        weight_row_t r;
        int s;
        sum = '0;
        r = w;
        for (s = 0; s < SLOTS; s++)
            sum += 64'(w[s]);
        if (sum != 0)
        begin
            for (s = 0; s < SLOTS; s++)
                r[s] = WEIGHT_W'((64'(w[s]) * 64'(ONE_FIX)) / sum);
        end
        return r;
    endfunction

    function automatic request_t make_request(input logic [KIND_W-1:0] kind,
                                              input int unsigned vtx,
                                              input int unsigned bone,
                                              input int unsigned weight);
        request_t r;
        r.kind = kind;
        r.vertex_index = VIDX_W'(vtx);
        r.bone_index = BONE_W'(bone);
        r.weight = WEIGHT_W'(weight);
        return r;
    endfunction

    // Apply one accepted request to the shadow store and queue its results.
    task automatic compute_influence_results(input request_t req);
        int unsigned         base;
        int                  s;
        int                  j;
        int                  free_slot;
        int                  small_slot;
        logic [WEIGHT_W-1:0] w_in;
        logic [WEIGHT_W-1:0] kw;
        logic [BONE_W-1:0]   kb;
        weight_row_t         w;
        bone_row_t           b;
        result_t             res;
        res = '0;
        res.last = 1'b1;
        base = int'(req.vertex_index) * SLOTS;
        if (req.vertex_index >= shadow_vertex_limit || req.vertex_index >= VERTICES)
        begin
            res.status = ST_BAD_VERTEX;
            awaited_results.insert(awaited_results.size(), res);
        end
        else if (req.kind == KIND_ADD)
        begin
            if (req.bone_index >= shadow_bone_limit)
            begin
                res.status = ST_BAD_BONE;
            end
            else
            begin
                w_in = (req.weight > ONE_FIX) ? ONE_FIX : req.weight;
                free_slot = -1;
                for (s = 0; s < SLOTS; s++)
                    if (free_slot < 0 && shadow_weight[base + s] == 0)
                        free_slot = s;
                if (free_slot >= 0)
                begin
                    shadow_bone[base + free_slot] = req.bone_index;
                    shadow_weight[base + free_slot] = w_in;
                    res.status = ST_FREE;
                end
                else
                begin
                    // Lowest slot wins a tie for the smallest weight.
                    small_slot = 0;
                    for (s = 1; s < SLOTS; s++)
                        if (shadow_weight[base + s] < shadow_weight[base + small_slot])
                            small_slot = s;
                    if (w_in > shadow_weight[base + small_slot])
                    begin
                        shadow_bone[base + small_slot] = req.bone_index;
                        shadow_weight[base + small_slot] = w_in;
                        res.status = ST_REPLACED;
                    end
                    else
                    begin
                        res.status = ST_DROPPED;
                    end
                end
            end
            awaited_results.insert(awaited_results.size(), res);
        end
        else
        begin
            for (s = 0; s < SLOTS; s++)
            begin
                w[s] = shadow_weight[base + s];
                b[s] = shadow_bone[base + s];
            end
            w = normalize_weights(w);
            // Stable insertion sort, largest weight first.
            for (s = 1; s < SLOTS; s++)
            begin
                kw = w[s];
                kb = b[s];
                j = s - 1;
                while (j >= 0 && w[j] < kw)
                begin
                    w[j + 1] = w[j];
                    b[j + 1] = b[j];
                    j--;
                end
                w[j + 1] = kw;
                b[j + 1] = kb;
            end
            w = normalize_weights(w);
            for (s = 0; s < SLOTS; s++)
            begin
                shadow_weight[base + s] = w[s];
                shadow_bone[base + s] = b[s];
                res.status = ST_READOUT;
                res.slot_bone = b[s];
                res.slot_weight = w[s];
                res.last = (s == SLOTS - 1);
                awaited_results.insert(awaited_results.size(), res);
            end
        end
    endtask

    // Present one request after a random gap and wait until it is taken.
    task automatic issue_request(input request_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        compute_influence_results(req);
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic settle_idle();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input int unsigned value);
        settle_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_VERTEX_LIMIT)
            shadow_vertex_limit = VLIM_W'(value);
        else
            shadow_bone_limit = BLIM_W'(value);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d",
                         $time, result.status, result.slot_bone, result.slot_weight,
                         result.last);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("status", 32'(want.status), 32'(result.status));
                compare_field("slot_bone", 32'(want.slot_bone), 32'(result.slot_bone));
                compare_field("slot_weight", 32'(want.slot_weight),
                              32'(result.slot_weight));
                compare_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // Empty vertex, free slots, zero and oversized weights, drops and ties.
    task automatic test_fill_and_finalize();
        issue_request(make_request(KIND_FINALIZE, 0, 0, 0));
        issue_request(make_request(KIND_ADD, 5, 7, 0));
        issue_request(make_request(KIND_ADD, 5, 9, 131071));
        issue_request(make_request(KIND_ADD, 5, 3, 100));
        issue_request(make_request(KIND_ADD, 5, 4, 100));
        issue_request(make_request(KIND_ADD, 5, 1, 1));
        issue_request(make_request(KIND_ADD, 5, 2, 1));
        issue_request(make_request(KIND_ADD, 5, 2, 2));
        issue_request(make_request(KIND_FINALIZE, 5, 255, 131071));
        issue_request(make_request(KIND_FINALIZE, 5, 0, 0));
        issue_request(make_request(KIND_ADD, 1023, 255, 65536));
        issue_request(make_request(KIND_FINALIZE, 1023, 0, 0));
        settle_idle();
    endtask

    // A full row of equal weights: the replacement hits the lowest slot.
    task automatic test_equal_weights();
        int s;
        for (s = 0; s < SLOTS; s++)
            issue_request(make_request(KIND_ADD, 6, 10 + s, 50));
        issue_request(make_request(KIND_ADD, 6, 170, 60));
        issue_request(make_request(KIND_FINALIZE, 6, 0, 0));
        settle_idle();
    endtask

    // Bad vertex on both kinds, bad bone, and the vertex check taking priority.
    task automatic test_limits();
        write_limit(CFG_VERTEX_LIMIT, 0);
        issue_request(make_request(KIND_ADD, 0, 0, 10));
        issue_request(make_request(KIND_FINALIZE, 0, 0, 0));
        write_limit(CFG_VERTEX_LIMIT, 1);
        issue_request(make_request(KIND_FINALIZE, 1, 0, 0));
        write_limit(CFG_BONE_LIMIT, 0);
        issue_request(make_request(KIND_ADD, 0, 0, 500));
        issue_request(make_request(KIND_ADD, 1, 255, 500));
        issue_request(make_request(KIND_FINALIZE, 0, 0, 0));
        write_limit(CFG_VERTEX_LIMIT, 1024);
        write_limit(CFG_BONE_LIMIT, 256);
    endtask

    function automatic int unsigned pick_weight();
        int unsigned w;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 65536;
            2:       w = $urandom_range(65537, 131071);
            3, 4:    w = $urandom_range(1, 255);
            default: w = $urandom_range(1, 65535);
        endcase
        return w;
    endfunction

    // One configuration with mostly add runs closed by a finalize, plus noise.
    task automatic run_random_phase(input int unsigned vlim, input int unsigned blim,
                                    input bit steady, input int count);
        int          sent;
        int          lim;
        int          span;
        int          pool_base;
        int          adds;
        int          k;
        int unsigned vtx;
        int unsigned bone;
        write_limit(CFG_VERTEX_LIMIT, vlim);
        write_limit(CFG_BONE_LIMIT, blim);
        no_idle = steady;
        lim = (vlim > 1024) ? 1024 : vlim;
        span = (lim < 4) ? lim : 4;
        pool_base = (lim > 4) ? $urandom_range(0, lim - 4) : 0;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                vtx = (span == 0) ? $urandom_range(0, 1023)
                                  : pool_base + $urandom_range(0, span - 1);
                adds = $urandom_range(0, 7);
                for (k = 0; k < adds; k++)
                begin
                    if (blim == 0 || $urandom_range(0, 19) == 0)
                        bone = $urandom_range(0, 255);
                    else
                        bone = $urandom_range(0, blim - 1);
                    issue_request(make_request(KIND_ADD, vtx, bone, pick_weight()));
                end
                issue_request(make_request(KIND_FINALIZE, vtx, $urandom_range(0, 255),
                                           $urandom_range(0, 131071)));
                sent += adds + 1;
            end
            else
            begin
                issue_request(make_request(KIND_W'($urandom_range(0, 1)),
                                           $urandom_range(0, 1023),
                                           $urandom_range(0, 255),
                                           $urandom_range(0, 131071)));
                sent++;
            end
        end
        settle_idle();
    endtask

    task automatic test_random_meshes();
        run_random_phase(1024, 256, 1'b0, 50);
        run_random_phase($urandom_range(1, 1024), $urandom_range(1, 256), 1'b0, 50);
        run_random_phase(1024, $urandom_range(0, 256), 1'b1, 50);
        run_random_phase($urandom_range(0, 1024), 256, 1'b0, 50);
        run_random_phase($urandom_range(900, 1024), $urandom_range(200, 256), 1'b1, 50);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < VERTICES * SLOTS; i++)
        begin
            shadow_bone[i] = '0;
            shadow_weight[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // The slot memory is cleared row by row before the first request.
        while (busy)
            @(posedge clk);
        test_fill_and_finalize();
        test_equal_weights();
        test_limits();
        test_random_meshes();
        settle_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run-away guard.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/bitk_pkg.sv
design/bitk_div.sv
design/bitk_store.sv
design/bone_influence_top_k.sv
tb/sv/testbench.sv
